@@ design/fastq_record_framer_defines.svh @@
// ---------------------------------------------------------------------------
// fastq_record_framer_defines
// assertion macros used by the top-level framer source
// ---------------------------------------------------------------------------
`ifndef FASTQ_RECORD_FRAMER_DEFINES_SVH
`define FASTQ_RECORD_FRAMER_DEFINES_SVH

`ifndef SYNTHESIS

`define FQRF_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("framer check failed");

`define FQRF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("framer check failed");

`else

`define FQRF_ASSERT_IMPLY(lbl, ante, cons)

`define FQRF_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ design/fqrf_pkg.sv @@
// ---------------------------------------------------------------------------
// fqrf_pkg
// types and constants of the sequencing record framer
// ---------------------------------------------------------------------------
package fqrf_pkg;

  localparam int MAX_SEQ_LEN  = 4096;
  localparam int MAX_HEAD_LEN = 1023;

  localparam int POS_W  = 24;
  localparam int HEAD_W = 10;
  localparam int SEQ_W  = 12;
  localparam int LL_W   = 13;
  localparam int STAT_W = 3;

  // classify queue and result queue depths, powers of two
  localparam int CQ_DEPTH = 4;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);
  localparam int RQ_DEPTH = 2;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);

  localparam logic [7:0] CH_AT = 8'h40;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SP = 8'h20;

  localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_TITLE  = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY_PLUS = 3'd2;
  localparam logic [STAT_W-1:0] ST_MISMATCH   = 3'd3;
  localparam logic [STAT_W-1:0] ST_TOO_LONG   = 3'd4;
  localparam logic [STAT_W-1:0] ST_TRUNC      = 3'd5;

  localparam logic CFG_USE_HEADERS   = 1'b0;
  localparam logic CFG_KEEP_COMMENTS = 1'b1;

  typedef enum logic [1:0] {
    LN_TITLE,
    LN_BASES,
    LN_PLUS,
    LN_QUAL
  } line_t;

  typedef struct packed {
    logic is_lf;
    logic is_cr;
    logic is_at;
    logic is_sp;
    logic last;
  } cls_t;

  typedef struct packed {
    logic       use_headers;
    logic       keep_comments;
  } cfg_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  record_offset;
    logic [HEAD_W-1:0] head_len;
    logic [POS_W-1:0]  seq_offset;
    logic [SEQ_W-1:0]  seq_len;
    logic [POS_W-1:0]  qual_offset;
  } res_t;

endpackage

@@ design/fastq_record_framer.sv @@
// ---------------------------------------------------------------------------
// fastq_record_framer
// splits a byte stream into four-line sequencing records
// ---------------------------------------------------------------------------
// Takes one byte beat per cycle, sustained, whenever the result queue has
// room. A byte passes a four-entry classify queue and then the line tracker,
// which writes the result of the record that the byte ends into a two-entry
// result queue, where it waits until popped. Configuration is read when a
// record is emitted; write it only while the block is idle.
module fastq_record_framer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_chunk_end,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_status,
  output logic [23:0] out_record_offset,
  output logic [9:0]  out_head_len,
  output logic [23:0] out_seq_offset,
  output logic [11:0] out_seq_len,
  output logic [23:0] out_qual_offset,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_data
);
  import fqrf_pkg::*;

  `include "fastq_record_framer_defines.svh"

  cfg_t cfg_r;
  logic cls_valid, cls_pop;
  cls_t cls_beat;
  res_t res_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.use_headers   <= 1'b1;
      cfg_r.keep_comments <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_USE_HEADERS:   cfg_r.use_headers   <= cfg_data;
        CFG_KEEP_COMMENTS: cfg_r.keep_comments <= cfg_data;
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  fqrf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_data_byte (in_data_byte),
    .in_chunk_end (in_chunk_end),
    .cls_valid    (cls_valid),
    .cls_beat     (cls_beat),
    .cls_pop      (cls_pop)
  );

  fqrf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cls_valid (cls_valid),
    .cls_beat  (cls_beat),
    .cls_pop   (cls_pop),
    .empty     (empty),
    .pop       (pop),
    .res_head  (res_head)
  );

  assign out_status        = res_head.status;
  assign out_record_offset = res_head.record_offset;
  assign out_head_len      = res_head.head_len;
  assign out_seq_offset    = res_head.seq_offset;
  assign out_seq_len       = res_head.seq_len;
  assign out_qual_offset   = res_head.qual_offset;

  `FQRF_ASSERT_IMPLY(a_status_known, !empty, out_status <= ST_TRUNC)
  `FQRF_ASSERT_IMPLY(a_err_fields_zero, !empty && out_status != ST_OK,
    out_head_len == '0 && out_seq_len == '0 && out_seq_offset == '0 && out_qual_offset == '0)
  `FQRF_ASSERT_IMPLY(a_head_off, !empty && out_status == ST_OK && !cfg_r.use_headers,
    out_head_len == '0)
  `FQRF_ASSERT_NEXT(a_empty_holds, empty && !push && !cls_valid, empty)

endmodule

@@ design/fqrf_front.sv @@
// ---------------------------------------------------------------------------
// fqrf_front
// accepts raw bytes, classifies them and queues the classified beats
// ---------------------------------------------------------------------------
module fqrf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         in_data_byte,
  input  logic               in_chunk_end,
  output logic               cls_valid,
  output fqrf_pkg::cls_t     cls_beat,
  input  logic               cls_pop
);
  import fqrf_pkg::*;

  cls_t             q_r [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CQ_AW:0]   cnt_r, cnt_nxt;
  logic             do_push, do_pop;
  cls_t             cls_in;

  always_comb begin
    cls_in.is_lf = (in_data_byte == CH_LF);
    cls_in.is_cr = (in_data_byte == CH_CR);
    cls_in.is_at = (in_data_byte == CH_AT);
    cls_in.is_sp = (in_data_byte == CH_SP);
    cls_in.last  = in_chunk_end;
  end

  assign full      = (cnt_r == (CQ_AW+1)'(CQ_DEPTH));
  assign cls_valid = (cnt_r != '0);
  assign cls_beat  = q_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = cls_pop && cls_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (CQ_AW+1)'(do_push) - (CQ_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= cls_in;
    end
  end

endmodule

@@ design/fqrf_back.sv @@
// ---------------------------------------------------------------------------
// fqrf_back
// line tracker: walks the record lines and queues finished results
// ---------------------------------------------------------------------------
module fqrf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  fqrf_pkg::cfg_t     cfg,
  input  logic               cls_valid,
  input  fqrf_pkg::cls_t     cls_beat,
  output logic               cls_pop,
  output logic               empty,
  input  logic               pop,
  output fqrf_pkg::res_t     res_head
);
  import fqrf_pkg::*;

  line_t              line_r, line_nxt;
  logic [LL_W-1:0]    ll_r, ll_nxt;
  logic [HEAD_W-1:0]  title_len_r, title_len_nxt;
  logic [HEAD_W-1:0]  head_len_r, head_len_nxt;
  logic               space_r, space_nxt;
  logic               title_ok_r, title_ok_nxt;
  logic               cr_pend_r, cr_pend_nxt;
  logic               halted_r, halted_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [POS_W-1:0]   rec_start_r, rec_start_nxt;
  logic [POS_W-1:0]   bases_start_r, bases_start_nxt;
  logic [POS_W-1:0]   qual_start_r, qual_start_nxt;
  logic [SEQ_W-1:0]   base_cnt_r, base_cnt_nxt;

  res_t               oq_r [RQ_DEPTH];
  logic [RQ_AW-1:0]   owr_r, ord_r;
  logic [RQ_AW:0]     ocnt_r;
  logic               opop, room, step;
  logic               emit, fin_q, term;
  res_t               res;

  assign opop     = pop && !empty;
  assign empty    = (ocnt_r == '0);
  assign room     = (ocnt_r != (RQ_AW+1)'(RQ_DEPTH)) || opop;
  assign step     = cls_valid && room;
  assign cls_pop  = step;
  assign res_head = oq_r[ord_r];
  assign term     = cls_beat.is_lf || cls_beat.is_cr;

  always_comb begin
    line_nxt        = line_r;
    ll_nxt          = ll_r;
    title_len_nxt   = title_len_r;
    head_len_nxt    = head_len_r;
    space_nxt       = space_r;
    title_ok_nxt    = title_ok_r;
    cr_pend_nxt     = cr_pend_r;
    halted_nxt      = halted_r;
    pos_nxt         = pos_r;
    rec_start_nxt   = rec_start_r;
    bases_start_nxt = bases_start_r;
    qual_start_nxt  = qual_start_r;
    base_cnt_nxt    = base_cnt_r;
    emit            = 1'b0;
    fin_q           = 1'b0;
    res             = '0;

    if (step) begin
      if (!halted_r) begin
        if (cr_pend_r && cls_beat.is_lf) begin
          cr_pend_nxt = 1'b0;
        end else begin
          cr_pend_nxt = cls_beat.is_cr;
          unique case (line_r)
            LN_TITLE: begin
              if (title_len_r == '0) rec_start_nxt = pos_r;
              if (term) begin
                if (title_len_r == '0 || !title_ok_r) begin
                  emit       = 1'b1;
                  res.status = ST_BAD_TITLE;
                end else begin
                  line_nxt = LN_BASES;
                  ll_nxt   = '0;
                end
              end else begin
                if (title_len_r == '0) title_ok_nxt = cls_beat.is_at;
                if (title_len_r < HEAD_W'(MAX_HEAD_LEN)) title_len_nxt = title_len_r + 1'b1;
                if (cls_beat.is_sp) space_nxt = 1'b1;
                if (!(space_r || cls_beat.is_sp) && head_len_r < HEAD_W'(MAX_HEAD_LEN)) begin
                  head_len_nxt = head_len_r + 1'b1;
                end
              end
            end
            LN_BASES: begin
              if (ll_r == '0) bases_start_nxt = pos_r;
              if (term) begin
                base_cnt_nxt = ll_r[SEQ_W-1:0];
                ll_nxt       = '0;
                line_nxt     = LN_PLUS;
              end else if (ll_r >= LL_W'(MAX_SEQ_LEN - 1)) begin
                emit       = 1'b1;
                res.status = ST_TOO_LONG;
              end else begin
                ll_nxt = ll_r + 1'b1;
              end
            end
            LN_PLUS: begin
              if (term) begin
                if (ll_r == '0) begin
                  emit       = 1'b1;
                  res.status = ST_EMPTY_PLUS;
                end else begin
                  ll_nxt   = '0;
                  line_nxt = LN_QUAL;
                end
              end else if (ll_r < LL_W'(MAX_SEQ_LEN)) begin
                ll_nxt = ll_r + 1'b1;
              end
            end
            LN_QUAL: begin
              if (ll_r == '0) qual_start_nxt = pos_r;
              if (term) begin
                fin_q = 1'b1;
              end else if (ll_r < LL_W'(MAX_SEQ_LEN)) begin
                ll_nxt = ll_r + 1'b1;
              end
            end
            default: begin
              line_nxt = LN_TITLE;
            end
          endcase
        end

        // chunk close on a record still open
        if (cls_beat.last && !emit && !fin_q) begin
          if (line_nxt == LN_QUAL) begin
            fin_q = 1'b1;
          end else if (!(line_nxt == LN_TITLE && title_len_nxt == '0)) begin
            emit       = 1'b1;
            res.status = ST_TRUNC;
          end
        end

        if (fin_q) begin
          emit = 1'b1;
          if (ll_nxt != {1'b0, base_cnt_nxt}) begin
            res.status = ST_MISMATCH;
          end else begin
            res.status      = ST_OK;
            res.head_len    = cfg.use_headers ?
                              (cfg.keep_comments ? title_len_nxt : head_len_nxt) : '0;
            res.seq_offset  = bases_start_nxt;
            res.seq_len     = base_cnt_nxt;
            res.qual_offset = qual_start_nxt;
            line_nxt        = LN_TITLE;
            ll_nxt          = '0;
            title_len_nxt   = '0;
            head_len_nxt    = '0;
            space_nxt       = 1'b0;
            title_ok_nxt    = 1'b0;
            base_cnt_nxt    = '0;
          end
        end
        if (emit && res.status != ST_OK) halted_nxt = 1'b1;
        res.record_offset = rec_start_nxt;
      end

      if (cls_beat.last) begin
        line_nxt        = LN_TITLE;
        ll_nxt          = '0;
        title_len_nxt   = '0;
        head_len_nxt    = '0;
        space_nxt       = 1'b0;
        title_ok_nxt    = 1'b0;
        base_cnt_nxt    = '0;
        cr_pend_nxt     = 1'b0;
        halted_nxt      = 1'b0;
        pos_nxt         = '0;
        rec_start_nxt   = '0;
        bases_start_nxt = '0;
        qual_start_nxt  = '0;
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r        <= LN_TITLE;
      ll_r          <= '0;
      title_len_r   <= '0;
      head_len_r    <= '0;
      space_r       <= 1'b0;
      title_ok_r    <= 1'b0;
      cr_pend_r     <= 1'b0;
      halted_r      <= 1'b0;
      pos_r         <= '0;
      rec_start_r   <= '0;
      bases_start_r <= '0;
      qual_start_r  <= '0;
      base_cnt_r    <= '0;
      owr_r         <= '0;
      ord_r         <= '0;
      ocnt_r        <= '0;
    end else begin
      line_r        <= line_nxt;
      ll_r          <= ll_nxt;
      title_len_r   <= title_len_nxt;
      head_len_r    <= head_len_nxt;
      space_r       <= space_nxt;
      title_ok_r    <= title_ok_nxt;
      cr_pend_r     <= cr_pend_nxt;
      halted_r      <= halted_nxt;
      pos_r         <= pos_nxt;
      rec_start_r   <= rec_start_nxt;
      bases_start_r <= bases_start_nxt;
      qual_start_r  <= qual_start_nxt;
      base_cnt_r    <= base_cnt_nxt;
      if (emit) owr_r <= owr_r + 1'b1;
      if (opop) ord_r <= ord_r + 1'b1;
      ocnt_r        <= ocnt_r + (RQ_AW+1)'(emit) - (RQ_AW+1)'(opop);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      oq_r[owr_r] <= res;
    end
  end

endmodule
